// ===== design/toroidal_clipmap_scroll_tracker_macros.svh =====
// Assertion macros for the clipmap scroll tracker checker.
`ifndef TOROIDAL_CLIPMAP_SCROLL_TRACKER_MACROS_SVH
`define TOROIDAL_CLIPMAP_SCROLL_TRACKER_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define TCST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TCST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/tcst_pkg.sv =====
// Package for the clipmap scroll tracker: constants, types, helpers.
`timescale 1ns / 1ps
package tcst_pkg;
  localparam int MAX_LEVELS = 8;
  localparam int MAX_RESOLUTION = 256;
  localparam int LVL_W = $clog2(MAX_LEVELS);
  localparam int RES_W = $clog2(MAX_RESOLUTION + 1);
  localparam int PHY_W = $clog2(MAX_RESOLUTION);

  localparam logic [1:0] KIND_SPAN = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd1;
  localparam logic [1:0] KIND_ADDR = 2'd2;

  localparam logic OP_SCROLL = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  localparam logic [0:0] REG_RESOLUTION = 1'd0;
  localparam logic [0:0] REG_BASE_SHIFT = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [31:0] span_min_x;
    logic [31:0] span_min_y;
    logic [31:0] span_min_z;
    logic [31:0] span_max_x;
    logic [31:0] span_max_y;
    logic [31:0] span_max_z;
    logic [31:0] shift_x;
    logic [31:0] shift_y;
    logic [31:0] shift_z;
    logic [23:0] flat_index;
  } result_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  level;
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
    logic [31:0] world_x;
    logic [31:0] world_y;
    logic [31:0] world_z;
  } item_t;
endpackage

// ===== design/tcst_if.sv =====
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
interface tcst_item_if;
  import tcst_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcst_result_if;
  import tcst_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tcst_wrap_mod.sv =====
// Iterative signed modulo by the window resolution, one quotient bit a cycle.
`timescale 1ns / 1ps
module tcst_wrap_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 value,
  input  logic [tcst_pkg::RES_W-1:0]  modulus,
  output logic                        done,
  output logic [tcst_pkg::PHY_W-1:0]  result
);
  import tcst_pkg::*;
  logic [31:0]      mag;
  logic [RES_W:0]   rem;
  logic [5:0]       cnt;
  logic             neg;
  logic             busy;
  logic [RES_W+1:0] trial;

  assign trial = {rem, mag[31]} - {2'b00, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= value[31];
        mag  <= value[31] ? (32'd0 - value) : value;
        rem  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        mag <= {mag[30:0], 1'b0};
        if (!trial[RES_W+1]) rem <= trial[RES_W:0];
        else rem <= {rem[RES_W-1:0], mag[31]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Fold negative remainder into [0, res).
  logic [RES_W:0] fixed;
  always_comb begin
    if (neg && rem != '0) fixed = {1'b0, modulus} - rem;
    else fixed = rem;
  end
  assign result = fixed[PHY_W-1:0];
endmodule

// ===== design/toroidal_clipmap_scroll_tracker.sv =====
// Top level of the toroidal clipmap scroll tracker.
// Keeps a toroidal origin per clipmap level in one synchronous origin memory
// (registered read) plus a flip-flop seeded bit per level. A level that
// is not yet seeded reads its origin as zero, so the memory needs no clearing
// pass after reset. One item is handled at a time. A scroll gives up to three
// span results and waits while the output stalls; a resolve runs three modulo
// passes, each a start, 32 quotient steps and a hand-off, then two Horner steps
// for the flat index and the result load. Items whose level is beyond the level
// count are dropped. Results sit in an output register, so the block stalls
// only while a result waits. Resolution 0 acts as 1 and values above the
// maximum saturate.
`timescale 1ns / 1ps
module toroidal_clipmap_scroll_tracker (
  input  logic        clk,
  input  logic        rst,
  tcst_item_if.sink   item,
  tcst_result_if.source res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_FLAT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [8:0] resolution;
  logic [4:0] base_cell_shift;

  // Config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution      <= 9'd64;
      base_cell_shift <= 5'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_RESOLUTION: resolution <= pwdata[8:0];
        REG_BASE_SHIFT: base_cell_shift <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_RESOLUTION: prdata = {23'd0, resolution};
      default:        prdata = {27'd0, base_cell_shift};
    endcase
  end

  logic [RES_W-1:0] eres;
  always_comb begin
    if (resolution == 9'd0) eres = RES_W'(1);
    else if (32'(resolution) > MAX_RESOLUTION) eres = RES_W'(MAX_RESOLUTION);
    else eres = RES_W'(resolution);
  end

  // Origin memory: x,y,z packed per level.
  logic [95:0] org_mem [MAX_LEVELS];
  logic [95:0] org_rd;
  logic        mem_we;
  logic [95:0] mem_wd;
  logic [MAX_LEVELS-1:0] seeded;

  item_t cur;
  logic [LVL_W-1:0] lv;
  assign lv = cur.level[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) org_mem[lv] <= mem_wd;
    org_rd <= org_mem[lv];
  end

  // Scroll arithmetic, registered in CALC.
  logic [31:0] corner [3];
  logic [31:0] wmax   [3];
  logic [31:0] sh     [3];
  logic [31:0] delta  [3];
  logic [31:0] old    [3];
  logic [31:0] cam    [3];
  logic [5:0]  stot;
  logic [4:0]  s;

  assign stot = 6'(base_cell_shift) + 6'(cur.level);
  assign s = (stot > 6'd31) ? 5'd31 : stot[4:0];
  assign cam[0] = cur.cam_x;
  assign cam[1] = cur.cam_y;
  assign cam[2] = cur.cam_z;
  // unseeded level: origin is taken as zero, since the memory is never reset
  assign old[0] = seeded[lv] ? org_rd[31:0]  : 32'd0;
  assign old[1] = seeded[lv] ? org_rd[63:32] : 32'd0;
  assign old[2] = seeded[lv] ? org_rd[95:64] : 32'd0;

  logic [31:0] c_corner [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_corner[i] = 32'($signed(cam[i]) >>> s) - 32'(eres >> 1);
    end
  end

  logic [2:0] axis_left;
  logic       first_unseeded;
  result_t    r;
  logic       r_valid;

  // Resolve datapath
  logic              mod_start, mod_done;
  logic [31:0]       mod_in;
  logic [PHY_W-1:0]  mod_res;
  logic [PHY_W-1:0]  phys [3];
  logic [1:0]        mod_ax;
  logic [31:0]       flat_acc;
  logic [1:0]        flat_step;

  tcst_wrap_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .value(mod_in),
    .modulus(eres), .done(mod_done), .result(mod_res)
  );

  always_comb begin
    case (mod_ax)
      2'd0:    mod_in = cur.world_x + old[0];
      2'd1:    mod_in = cur.world_y + old[1];
      default: mod_in = cur.world_z + old[2];
    endcase
  end

  assign item.ready = (state == S_IDLE);
  assign res_out.valid = r_valid;
  assign res_out.data = r;

  logic [1:0] next_ax;
  logic [2:0] rem_after;
  always_comb begin
    next_ax = 2'd0;
    if (axis_left[0]) next_ax = 2'd0;
    else if (axis_left[1]) next_ax = 2'd1;
    else next_ax = 2'd2;
    rem_after = axis_left;
    rem_after[next_ax] = 1'b0;
  end

  logic [31:0] mag_raw, mag;
  logic        up;
  always_comb begin
    up = !delta[next_ax][31];
    mag_raw = up ? delta[next_ax] : 32'd0 - delta[next_ax];
    mag = (mag_raw > 32'(eres)) ? 32'(eres) : mag_raw;
  end

  // Output register: loaded when a result is ready and the slot is free.
  result_t r_next;
  logic    r_load;
  assign r_load = ((state == S_EMIT) || (state == S_FLAT && flat_step == 2'd2)) &&
                  (!r_valid || res_out.ready);

  always_comb begin
    r_next = '0;
    if (state == S_FLAT) begin
      r_next.kind       = KIND_ADDR;
      r_next.last       = 1'b1;
      r_next.flat_index = flat_acc[23:0];
    end else if (first_unseeded) begin
      // whole window on first scroll of a level
      r_next.kind = KIND_SPAN;
      r_next.last = 1'b1;
      r_next.span_min_x = corner[0]; r_next.span_min_y = corner[1];
      r_next.span_min_z = corner[2];
      r_next.span_max_x = wmax[0]; r_next.span_max_y = wmax[1];
      r_next.span_max_z = wmax[2];
      r_next.shift_x = sh[0]; r_next.shift_y = sh[1]; r_next.shift_z = sh[2];
    end else if (axis_left == 3'b000) begin
      r_next.kind = KIND_NONE;
      r_next.last = 1'b1;
    end else begin
      r_next.kind = KIND_SPAN;
      r_next.last = (rem_after == 3'b000);
      r_next.span_min_x = (next_ax == 2'd0 && up) ? wmax[0] - mag : corner[0];
      r_next.span_min_y = (next_ax == 2'd1 && up) ? wmax[1] - mag : corner[1];
      r_next.span_min_z = (next_ax == 2'd2 && up) ? wmax[2] - mag : corner[2];
      r_next.span_max_x = (next_ax == 2'd0 && !up) ? corner[0] + mag : wmax[0];
      r_next.span_max_y = (next_ax == 2'd1 && !up) ? corner[1] + mag : wmax[1];
      r_next.span_max_z = (next_ax == 2'd2 && !up) ? corner[2] + mag : wmax[2];
      r_next.shift_x = sh[0]; r_next.shift_y = sh[1]; r_next.shift_z = sh[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r_valid <= 1'b0;
    else if (r_load) r_valid <= 1'b1;
    else if (res_out.ready) r_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (r_load) r <= r_next;
  end

  // Modulo start pulse: first axis from CALC, next axes on each done.
  always_ff @(posedge clk) begin
    if (rst) mod_start <= 1'b0;
    else mod_start <= (state == S_CALC && cur.op == OP_RESOLVE) ||
                      (state == S_MOD && mod_done && mod_ax != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seeded    <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (item.valid) begin
          cur <= item.data;
          if (32'(item.data.level) < MAX_LEVELS) state <= S_READ;
        end
        S_READ: state <= S_CALC;
        S_CALC: begin
          if (cur.op == OP_RESOLVE) begin
            mod_ax    <= 2'd0;
            state     <= S_MOD;
          end else begin
            for (int i = 0; i < 3; i++) begin
              corner[i] <= c_corner[i];
              wmax[i]   <= c_corner[i] + 32'(eres);
              sh[i]     <= (32'd0 - c_corner[i]) - old[i];
              delta[i]  <= c_corner[i] + old[i];
              axis_left[i] <= (c_corner[i] + old[i]) != 32'd0;
            end
            first_unseeded <= !seeded[lv];
            seeded[lv] <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: if (!r_valid || res_out.ready) begin
          if (first_unseeded || axis_left == 3'b000) begin
            state <= S_WAIT;
          end else begin
            axis_left <= rem_after;
            if (rem_after == 3'b000) state <= S_WAIT;
          end
        end
        S_MOD: if (mod_done) begin
          phys[mod_ax] <= mod_res;
          if (mod_ax == 2'd2) begin
            flat_acc  <= 32'(mod_res);
            flat_step <= 2'd0;
            state     <= S_FLAT;
          end else begin
            mod_ax    <= mod_ax + 2'd1;
          end
        end
        S_FLAT: begin
          // Horner: z*res + y, then *res + x
          if (flat_step == 2'd0) begin
            flat_acc  <= 32'(flat_acc * 32'(eres)) + 32'(phys[1]);
            flat_step <= 2'd1;
          end else if (flat_step == 2'd1) begin
            flat_acc  <= 32'(flat_acc * 32'(eres)) + 32'(phys[0]);
            flat_step <= 2'd2;
          end else if (!r_valid || res_out.ready) begin
            state        <= S_WAIT;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mem_we = (state == S_CALC) && (cur.op == OP_SCROLL);
  always_comb begin
    mem_wd[31:0]  = 32'd0 - c_corner[0];
    mem_wd[63:32] = 32'd0 - c_corner[1];
    mem_wd[95:64] = 32'd0 - c_corner[2];
  end
endmodule

// ===== design/tcst_checker.sv =====
// Port-level checker for the clipmap scroll tracker, with its bind.
`timescale 1ns / 1ps
`include "toroidal_clipmap_scroll_tracker_macros.svh"
module tcst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic        last,
  input logic [23:0] flat_index
);
  import tcst_pkg::*;
  `TCST_ASSERT_IMP(a_kind_range, clk, rst, out_valid, kind <= KIND_ADDR)
  `TCST_ASSERT_IMP(a_addr_last, clk, rst, out_valid && kind == KIND_ADDR, last)
  `TCST_ASSERT_IMP(a_span_flat, clk, rst, out_valid && kind != KIND_ADDR, flat_index == 24'd0)
  `TCST_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TCST_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind toroidal_clipmap_scroll_tracker tcst_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(item.valid), .in_ready(item.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .kind(res_out.data.kind), .last(res_out.data.last),
  .flat_index(res_out.data.flat_index)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the toroidal clipmap scroll tracker.
`timescale 1ns / 1ps
module testbench;
  import tcst_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcst_item_if   item_ch ();
  tcst_result_if res_ch ();

  toroidal_clipmap_scroll_tracker dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .res_out(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's registers and per-level window state.
  logic [8:0]  cfg_res;
  logic [4:0]  cfg_shift;
  logic [31:0] org_x [MAX_LEVELS];
  logic [31:0] org_y [MAX_LEVELS];
  logic [31:0] org_z [MAX_LEVELS];
  logic        seeded [MAX_LEVELS];

  item_t   pending_items [$];
  result_t expected_results [$];
  int      mismatches = 0;
  int      stall_cycles = 0;
  bit      tx_pause = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  function automatic logic [31:0] eff_res();
    if (cfg_res == 0) return 32'd1;
    if (cfg_res > MAX_RESOLUTION) return MAX_RESOLUTION;
    return {23'd0, cfg_res};
  endfunction

  function automatic logic [31:0] floor_mod(logic [31:0] v, logic [31:0] m);
    longint r;
    r = longint'($signed(v)) % longint'(m);
    if (r < 0) r += longint'(m);
    return r[31:0];
  endfunction

  // Works out the results an accepted item causes and, for a scroll, commits its state.
  task automatic predict_window(item_t it);
    logic [31:0] res, cam_cell, delta, mag;
    logic [31:0] cam [3];
    logic [31:0] old [3];
    logic [31:0] corner [3];
    logic [31:0] wmax [3];
    logic [31:0] neworg [3];
    logic [31:0] sh [3];
    logic [31:0] mn [3];
    logic [31:0] mx [3];
    logic [31:0] p [3];
    int sa;
    bit moved;
    result_t r;
    res = eff_res();
    old[0] = org_x[it.level]; old[1] = org_y[it.level]; old[2] = org_z[it.level];
    r = '0;
    if (it.op == OP_RESOLVE) begin
      p[0] = floor_mod(it.world_x + old[0], res);
      p[1] = floor_mod(it.world_y + old[1], res);
      p[2] = floor_mod(it.world_z + old[2], res);
      r.kind = KIND_ADDR;
      r.last = 1'b1;
      r.flat_index = 24'(p[0] + res * (p[1] + res * p[2]));
      expected_results.push_back(r);
      return;
    end
    cam[0] = it.cam_x; cam[1] = it.cam_y; cam[2] = it.cam_z;
    sa = cfg_shift + it.level;
    if (sa > 31) sa = 31;
    moved = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cam_cell = $signed(cam[i]) >>> sa;
      corner[i] = cam_cell - (res >> 1);
      wmax[i] = corner[i] + res;
      neworg[i] = -corner[i];
      sh[i] = neworg[i] - old[i];
      if (sh[i] != 0) moved = 1'b1;
    end
    if (!seeded[it.level]) begin
      r.kind = KIND_SPAN;
      r.span_min_x = corner[0]; r.span_min_y = corner[1]; r.span_min_z = corner[2];
      r.span_max_x = wmax[0]; r.span_max_y = wmax[1]; r.span_max_z = wmax[2];
      r.shift_x = sh[0]; r.shift_y = sh[1]; r.shift_z = sh[2];
      expected_results.push_back(r);
    end else if (!moved) begin
      r.kind = KIND_NONE;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < 3; i++) begin
        delta = corner[i] + old[i];
        if (delta != 0) begin
          mag = delta[31] ? -delta : delta;
          if (mag > res) mag = res;
          mn = corner; mx = wmax;
          if (!delta[31]) mn[i] = wmax[i] - mag;
          else mx[i] = corner[i] + mag;
          r = '0;
          r.kind = KIND_SPAN;
          r.span_min_x = mn[0]; r.span_min_y = mn[1]; r.span_min_z = mn[2];
          r.span_max_x = mx[0]; r.span_max_y = mx[1]; r.span_max_z = mx[2];
          r.shift_x = sh[0]; r.shift_y = sh[1]; r.shift_z = sh[2];
          expected_results.push_back(r);
        end
      end
    end
    // last flag goes on the final result of the item
    r = expected_results[$];
    r.last = 1'b1;
    expected_results[$] = r;
    org_x[it.level] = neworg[0];
    org_y[it.level] = neworg[1];
    org_z[it.level] = neworg[2];
    seeded[it.level] = 1'b1;
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.data <= '0;
    end else begin
      if (item_ch.valid && item_ch.ready) predict_window(item_ch.data);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) gap_left--;
        if (pending_items.size() > 0 && !tx_pause && gap_left == 0) begin
          item_ch.valid <= 1'b1;
          item_ch.data <= pending_items.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off counted down separately.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 7) < 5);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_ch.data);
      end else begin
        exp_r = expected_results.pop_front();
        if (res_ch.data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, res_ch.data);
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'(REG_RESOLUTION) * 4) cfg_res = value[8:0];
    else cfg_shift = value[4:0];
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || item_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    // the block may still be returning to idle after its last result
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t make_item(logic op, logic [2:0] lvl, logic [31:0] base);
    item_t it;
    it.op = op;
    it.level = lvl;
    it.cam_x = base + ($urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 8000)));
    it.cam_y = base + $urandom_range(0, 6000);
    it.cam_z = base - $urandom_range(0, 6000);
    it.world_x = ($urandom_range(0, 4) == 0) ? rand_word() : $urandom_range(0, 600) - 300;
    it.world_y = ($urandom_range(0, 4) == 0) ? rand_word() : $urandom_range(0, 600) - 300;
    it.world_z = ($urandom_range(0, 4) == 0) ? rand_word() : $urandom_range(0, 600) - 300;
    return it;
  endfunction

  task automatic random_phase(int count);
    logic [31:0] base;
    base = $urandom;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) base = rand_word();
      pending_items.push_back(make_item($urandom_range(0, 2) == 0,
                                        3'($urandom_range(0, 7)), base));
    end
  endtask

  initial begin
    item_t it;
    cfg_res = 9'd64;
    cfg_shift = 5'd8;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      org_x[l] = '0; org_y[l] = '0; org_z[l] = '0; seeded[l] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: resolve before seeding, first scroll, no move, extremes.
    it = '0; it.op = OP_RESOLVE; it.world_x = 32'h8000_0000; it.world_y = 32'h7fff_ffff;
    it.world_z = 32'hffff_ffff; pending_items.push_back(it);
    it = '0; it.op = OP_SCROLL; it.cam_x = 32'h0000_1000; pending_items.push_back(it);
    pending_items.push_back(it);
    it.cam_x = 32'h7fff_ffff; it.cam_y = 32'h8000_0000; it.cam_z = 32'hffff_ffff;
    pending_items.push_back(it);
    it.cam_x = 32'h8000_0000; it.cam_y = 32'h7fff_ffff; it.cam_z = 32'h0;
    pending_items.push_back(it);
    it.cam_x = 32'h8000_0100; pending_items.push_back(it);
    it.cam_y = 32'h7fff_ff00; it.cam_z = 32'h0000_0300; pending_items.push_back(it);
    it.op = OP_RESOLVE; it.world_x = 32'h7fff_ffff; it.world_y = 32'h0;
    it.world_z = 32'h8000_0000; pending_items.push_back(it);
    for (int l = 1; l < MAX_LEVELS; l++) begin
      it = '0; it.level = 3'(l); it.cam_x = 32'hffff_ffff; it.cam_y = 32'h5555_aaaa;
      it.cam_z = 32'haaaa_5555; pending_items.push_back(it);
    end
    it.op = OP_RESOLVE; it.level = 3'd7; it.world_x = 32'hffff_ffff;
    pending_items.push_back(it);
    drain();

    // Resolution extremes and the shift ceiling; the first phase also brings the
    // stall pressure: sender keeps offering while the receiver holds off.
    apb_write(3'(REG_RESOLUTION) * 4, 32'd0);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd31);
    random_phase(20);
    stall_cycles = 600;
    drain();

    apb_write(3'(REG_RESOLUTION) * 4, 32'd256);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd0);
    random_phase(50);
    drain();

    apb_write(3'(REG_RESOLUTION) * 4, 32'd511);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd24);
    random_phase(40);
    drain();

    apb_write(3'(REG_RESOLUTION) * 4, 32'd1);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd4);
    random_phase(40);
    drain();

    // Sender holds back mid-stream until every expected result is in.
    apb_write(3'(REG_RESOLUTION) * 4, 32'd37);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd6);
    random_phase(80);
    while (pending_items.size() > 40) @(posedge clk);
    tx_pause = 1'b1;
    while (item_ch.valid || expected_results.size() > 0) @(posedge clk);
    tx_pause = 1'b0;
    drain();

    apb_write(3'(REG_RESOLUTION) * 4, 32'd255);
    apb_write(3'(REG_BASE_SHIFT) * 4, 32'd12);
    random_phase(50);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/tcst_pkg.sv
design/tcst_if.sv
design/tcst_wrap_mod.sv
design/toroidal_clipmap_scroll_tracker.sv
design/tcst_checker.sv
test/testbench.sv
